>>> hdl/sobel_edge_line_buffer_filter_unit_defines.svh
// Assertion macros used by the Sobel edge filter top level.
`ifndef SOBEL_EDGE_LINE_BUFFER_FILTER_UNIT_DEFINES_SVH
`define SOBEL_EDGE_LINE_BUFFER_FILTER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SOBEL_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define SOBEL_CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/sobel_pkg.sv
// Shared types, constants and helper functions of the Sobel edge filter.
`timescale 1ns / 1ps

package sobel_pkg;

    // Configuration register map.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = CFG_INDEX_W'(1);

    localparam logic [12:0] ROWS_RESET = 13'd720;
    localparam logic [11:0] COLS_RESET = 12'd1280;
    localparam logic [7:0]  PIX_MAX    = 8'd255;

    // Item kinds.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_PAD   = 1'b1;

    // Queue between the front end and the filter back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    typedef logic [1:0] bank_t;
    typedef logic [1:0] rot_t;

    localparam bank_t BANK_0 = 2'd0;
    localparam bank_t BANK_1 = 2'd1;
    localparam bank_t BANK_2 = 2'd2;

    localparam rot_t ROT_0     = 2'd0;
    localparam rot_t ROT_1     = 2'd1;
    localparam rot_t ROT_2     = 2'd2;
    localparam rot_t ROT_RESET = ROT_2;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_in;
    } sobel_in_t;

    typedef struct packed {
        logic [7:0] edge_pixel;
        logic       frame_last;
    } sobel_out_t;

    // Line store access issued by the front end for one item.
    typedef struct packed {
        logic       wr_en;
        bank_t      wr_bank;
        logic [7:0] wr_data;
        bank_t      top_bank;
        bank_t      mid_bank;
    } mem_ctl_t;

    // Per-item control that is registered alongside the line store read.
    typedef struct packed {
        logic [7:0] btm;
        logic       clr;
        logic       last;
        logic       top_zero;
    } front_cmd_t;

    // One new window column plus its control, as queued for the back end.
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] btm;
        logic       clr;
        logic       last;
    } sobel_job_t;

    function automatic bank_t rot_top(input rot_t rot);
        bank_t b;
        case (rot)
            ROT_0:   b = BANK_1;
            ROT_1:   b = BANK_2;
            default: b = BANK_0;
        endcase
        return b;
    endfunction

    function automatic bank_t rot_mid(input rot_t rot);
        bank_t b;
        case (rot)
            ROT_0:   b = BANK_2;
            ROT_1:   b = BANK_0;
            default: b = BANK_1;
        endcase
        return b;
    endfunction

    function automatic bank_t rot_btm(input rot_t rot);
        bank_t b;
        case (rot)
            ROT_0:   b = BANK_0;
            ROT_1:   b = BANK_1;
            default: b = BANK_2;
        endcase
        return b;
    endfunction

    function automatic rot_t rot_advance(input rot_t rot);
        rot_t r;
        case (rot)
            ROT_0:   r = ROT_1;
            ROT_1:   r = ROT_2;
            default: r = ROT_0;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/sobel_front.sv
// Front end: frame position tracking, item classification and line store access.
`timescale 1ns / 1ps

module sobel_front
    import sobel_pkg::*;
#(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [12:0]                 frame_rows,
    input  logic [11:0]                 frame_cols,
    input  logic                        accept,
    input  sobel_in_t                   item,
    output mem_ctl_t                    mem_ctl,
    output logic [$clog2(MAX_COLS)-1:0] mem_addr,
    output logic                        cmd_valid,
    output front_cmd_t                  cmd
);

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int COL_W = $clog2(MAX_COLS);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    rot_t             rot_reg, rot_next;
    logic             cmd_valid_reg;
    front_cmd_t       cmd_reg;

    logic [ROW_W-1:0] rows_eff;
    logic [CNT_W-1:0] cols_eff;
    logic [CNT_W-1:0] cols_m1;
    logic             restart;
    logic [ROW_W-1:0] row_cur;
    logic [CNT_W-1:0] col_cnt;
    rot_t             rot_cur;
    logic [CNT_W-1:0] col;
    logic             end_row;
    logic             row_zero;
    logic             want_func;
    logic             fill;
    logic             emit;
    logic [7:0]       btm_data;

    // Register values outside the legal range are clamped.
    always_comb
    begin
        if (frame_rows == 13'd0)
            rows_eff = ROW_W'(1);
        else if (32'(frame_rows) > MAX_ROWS)
            rows_eff = ROW_W'(MAX_ROWS);
        else
            rows_eff = ROW_W'(frame_rows);

        if (frame_cols == 12'd0)
            cols_eff = CNT_W'(1);
        else if (32'(frame_cols) > MAX_COLS)
            cols_eff = CNT_W'(MAX_COLS);
        else
            cols_eff = CNT_W'(frame_cols);
    end

    assign cols_m1 = cols_eff - CNT_W'(1);

    // A row count beyond the frame, left by a register change, restarts the frame.
    assign restart = row_reg > rows_eff;
    assign row_cur = restart ? '0 : row_reg;
    assign col_cnt = restart ? '0 : col_reg;
    assign rot_cur = restart ? ROT_RESET : rot_reg;

    assign col      = (col_cnt >= cols_eff) ? cols_m1 : col_cnt;
    assign end_row  = (col == cols_m1);
    assign row_zero = (row_cur == '0);
    assign want_func = (row_cur < rows_eff) ? FUNC_PIXEL : FUNC_PAD;

    assign fill = accept && row_zero && (item.func == FUNC_PIXEL);
    assign emit = accept && !row_zero && (item.func == want_func);

    assign btm_data = (item.func == FUNC_PAD) ? 8'd0 : item.pixel_in;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        rot_next = rot_reg;
        if (accept)
        begin
            row_next = row_cur;
            col_next = col_cnt;
            rot_next = rot_cur;
        end
        if (fill)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = ROW_W'(1);
            end
            else
            begin
                col_next = col + CNT_W'(1);
            end
        end
        if (emit)
        begin
            if (end_row)
            begin
                col_next = '0;
                if (row_cur == rows_eff)
                begin
                    row_next = '0;
                    rot_next = ROT_RESET;
                end
                else
                begin
                    row_next = row_cur + ROW_W'(1);
                    rot_next = rot_advance(rot_cur);
                end
            end
            else
            begin
                col_next = col + CNT_W'(1);
            end
        end
    end

    // The top line of the first output row is the zero line above the image,
    // so the row zero fill writes only the middle store.
    always_comb
    begin
        mem_ctl.wr_en    = fill || emit;
        mem_ctl.wr_bank  = fill ? rot_mid(rot_cur) : rot_btm(rot_cur);
        mem_ctl.wr_data  = fill ? item.pixel_in : btm_data;
        mem_ctl.top_bank = rot_top(rot_cur);
        mem_ctl.mid_bank = rot_mid(rot_cur);
    end

    assign mem_addr = col[COL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            rot_reg       <= ROT_RESET;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            rot_reg       <= rot_next;
            cmd_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cmd_reg.btm      <= btm_data;
            cmd_reg.clr      <= (col_cnt == '0);
            cmd_reg.last     <= (row_cur == rows_eff) && end_row;
            cmd_reg.top_zero <= (row_cur == ROW_W'(1));
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

>>> hdl/sobel_lines.sv
// Three rotating line stores with one write and one registered read each.
`timescale 1ns / 1ps

module sobel_lines
    import sobel_pkg::*;
#(
    parameter int MAX_COLS = 2048
)
(
    input  logic                        clk,
    input  mem_ctl_t                    mem_ctl,
    input  logic [$clog2(MAX_COLS)-1:0] mem_addr,
    output logic [7:0]                  top_data,
    output logic [7:0]                  mid_data
);

    logic [7:0] rd_q [3];
    bank_t      top_sel_reg;
    bank_t      mid_sel_reg;

    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        logic [7:0] mem [MAX_COLS];
        logic [7:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (mem_ctl.wr_en && (mem_ctl.wr_bank == bank_t'(b)))
                mem[mem_addr] <= mem_ctl.wr_data;
            rd_reg <= mem[mem_addr];
        end

        assign rd_q[b] = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        top_sel_reg <= mem_ctl.top_bank;
        mid_sel_reg <= mem_ctl.mid_bank;
    end

    always_comb
    begin
        case (top_sel_reg)
            BANK_0:  top_data = rd_q[0];
            BANK_1:  top_data = rd_q[1];
            default: top_data = rd_q[2];
        endcase
        case (mid_sel_reg)
            BANK_0:  mid_data = rd_q[0];
            BANK_1:  mid_data = rd_q[1];
            default: mid_data = rd_q[2];
        endcase
    end

endmodule

>>> hdl/sobel_queue.sv
// Small FIFO of window columns between the front end and the filter back end.
`timescale 1ns / 1ps

module sobel_queue
    import sobel_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sobel_job_t        push_job,
    input  logic              pop,
    output logic              head_valid,
    output sobel_job_t        head_job,
    output logic [QLVL_W-1:0] level
);

    sobel_job_t        slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                level_reg <= level_reg + QLVL_W'(1);
            else if (pop && !push)
                level_reg <= level_reg - QLVL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    assign head_valid = (level_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

endmodule

>>> hdl/sobel_back.sv
// Back end: 3x3 window, Sobel gradients and the output register.
`timescale 1ns / 1ps

module sobel_back
    import sobel_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  sobel_job_t job,
    output logic       pop,
    output logic       out_valid,
    output sobel_out_t out_item,
    input  logic       out_stall
);

    // Window columns: index 0 is the top row, 2 the bottom row.
    logic [7:0] w0_reg [3];
    logic [7:0] w1_reg [3];
    logic       out_valid_reg;
    sobel_out_t out_item_reg;

    logic [7:0]        c0 [3];
    logic [7:0]        c1 [3];
    logic [7:0]        c2 [3];
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [7:0]        gx_c;
    logic [7:0]        gy_c;
    logic [8:0]        sum;
    logic [7:0]        edge_val;

    function automatic logic signed [11:0] ext(input logic [7:0] p);
        return $signed({4'b0000, p});
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 12'sd0)
            r = 8'd0;
        else if (v > 12'sd255)
            r = PIX_MAX;
        else
            r = v[7:0];
        return r;
    endfunction

    assign pop = job_valid && (!out_valid_reg || !out_stall);

    // The first item of each output row starts from cleared older columns.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c0[i] = job.clr ? 8'd0 : w0_reg[i];
            c1[i] = job.clr ? 8'd0 : w1_reg[i];
        end
        c2[0] = job.top;
        c2[1] = job.mid;
        c2[2] = job.btm;

        gx = (ext(c2[1]) <<< 1) - (ext(c0[1]) <<< 1)
           + ext(c2[0]) + ext(c2[2]) - ext(c0[0]) - ext(c0[2]);
        gy = (ext(c1[2]) <<< 1) - (ext(c1[0]) <<< 1)
           + ext(c0[2]) + ext(c2[2]) - ext(c0[0]) - ext(c2[0]);

        gx_c = clamp8(gx);
        gy_c = clamp8(gy);
        sum  = {1'b0, gx_c} + {1'b0, gy_c};
        edge_val = sum[8] ? PIX_MAX : sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w0_reg[i] <= 8'd0;
                w1_reg[i] <= 8'd0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    w0_reg[i] <= c1[i];
                    w1_reg[i] <= c2[i];
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg.edge_pixel <= edge_val;
            out_item_reg.frame_last <= job.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> hdl/sobel_edge_line_buffer_filter_unit.sv
// Top level of the Sobel 3x3 edge filter with rotating line stores.
//
//  Channel  Direction  Handshake               Payload
//  pix      in         pix_valid / pix_stall   pix_item  (func, pixel_in)
//  edge     out        edge_valid / edge_stall edge_item (edge_pixel, frame_last)
//  cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per clock is accepted in steady state, unless a stalled output fills the queue.
// A result reaches the output register through these registered steps in order:
// line store read and command register, queue write, then filter and output register.
// Input stalls when the queue and the read stage together hold four items.
// The line stores need no clearing after reset; items are taken right away.
`timescale 1ns / 1ps
`include "sobel_edge_line_buffer_filter_unit_defines.svh"

module sobel_edge_line_buffer_filter_unit
    import sobel_pkg::*;
#(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  sobel_in_t              pix_item,
    output logic                   edge_valid,
    input  logic                   edge_stall,
    output sobel_out_t             edge_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CU_W  = QLVL_W + 1;

    logic [12:0] frame_rows_reg;
    logic [11:0] frame_cols_reg;

    logic              pix_accept;
    mem_ctl_t          mem_ctl;
    logic [COL_W-1:0]  mem_addr;
    logic              cmd_valid;
    front_cmd_t        cmd;
    logic [7:0]        top_data;
    logic [7:0]        mid_data;
    sobel_job_t        push_job;
    logic              q_valid;
    sobel_job_t        q_job;
    logic              q_pop;
    logic [QLVL_W-1:0] q_level;
    logic [CU_W-1:0]   credit_use;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= ROWS_RESET;
            frame_cols_reg <= COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                REG_FRAME_COLS: frame_cols_reg <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // Items in the read stage already own a queue slot.
    assign credit_use = CU_W'(q_level) + CU_W'(cmd_valid);
    assign pix_stall  = (credit_use >= CU_W'(QDEPTH));
    assign pix_accept = pix_valid && !pix_stall;

    sobel_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_rows (frame_rows_reg),
        .frame_cols (frame_cols_reg),
        .accept     (pix_accept),
        .item       (pix_item),
        .mem_ctl    (mem_ctl),
        .mem_addr   (mem_addr),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    sobel_lines #(
        .MAX_COLS (MAX_COLS)
    ) u_lines (
        .clk      (clk),
        .mem_ctl  (mem_ctl),
        .mem_addr (mem_addr),
        .top_data (top_data),
        .mid_data (mid_data)
    );

    always_comb
    begin
        push_job.top  = cmd.top_zero ? 8'd0 : top_data;
        push_job.mid  = mid_data;
        push_job.btm  = cmd.btm;
        push_job.clr  = cmd.clr;
        push_job.last = cmd.last;
    end

    sobel_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_valid),
        .push_job   (push_job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_job),
        .level      (q_level)
    );

    sobel_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .pop       (q_pop),
        .out_valid (edge_valid),
        .out_item  (edge_item),
        .out_stall (edge_stall)
    );

    `SOBEL_CHECK_IMPL(a_push_has_room, cmd_valid, q_level < QLVL_W'(QDEPTH), "queue overflow")
    `SOBEL_CHECK(a_credit_bound, credit_use <= CU_W'(QDEPTH), "queue credit exceeded")
    `SOBEL_CHECK_IMPL(a_pop_nonempty, q_pop, q_level != '0, "pop from empty queue")

endmodule

>>> bench/sobel_edge_monitor.sv
// Watches the filter's channels, predicts every edge result and compares it with the output.
`timescale 1ns / 1ps

module sobel_edge_monitor
    import sobel_pkg::*;
#(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    input  logic                   pix_stall,
    input  sobel_in_t              pix_item,
    input  logic                   edge_valid,
    input  logic                   edge_stall,
    input  sobel_out_t             edge_item,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     outstanding
);

    logic [7:0]  line_mem [3][MAX_COLS];
    int          win [3][3];
    int unsigned row_cnt;
    int unsigned col_cnt;
    rot_t        rot;
    logic [12:0] rows_reg;
    logic [11:0] cols_reg;
    sobel_out_t  edge_due [$];
    sobel_out_t  want_res;
    int          fails;

    function automatic void restart_frame();
        row_cnt = 0;
        col_cnt = 0;
        rot = ROT_RESET;
        foreach (win[i, j])
        begin
            win[i][j] = 0;
        end
    endfunction

    function automatic void clear_old_cols();
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = 0;
            win[i][1] = 0;
        end
    endfunction

    function automatic int clip255(input int v);
        if (v < 0) return 0;
        if (v > int'(PIX_MAX)) return int'(PIX_MAX);
        return v;
    endfunction

    // Advances the line stores and the window by one item and queues its result, if any.
    task automatic predict_item(input sobel_in_t item);
        int unsigned rows;
        int unsigned cols;
        int unsigned col;
        bank_t       top;
        bank_t       mid;
        bank_t       btm;
        int          gx;
        int          gy;
        int          mag;
        sobel_out_t  res;

        rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        if (row_cnt > rows) restart_frame();
        col = (col_cnt >= cols) ? cols - 1 : col_cnt;

        // The first image row only primes the stores: zeros above, pixels in the middle.
        if (row_cnt == 0)
        begin
            if (item.func != FUNC_PIXEL) return;
            line_mem[BANK_0][col] = 8'd0;
            line_mem[BANK_1][col] = item.pixel_in;
            if (col + 1 >= cols)
            begin
                col_cnt = 0;
                row_cnt = 1;
                clear_old_cols();
            end
            else
            begin
                col_cnt = col + 1;
            end
            return;
        end

        if (item.func != ((row_cnt < rows) ? FUNC_PIXEL : FUNC_PAD)) return;

        case (rot)
            ROT_0:
            begin
                top = BANK_1;
                mid = BANK_2;
                btm = BANK_0;
            end
            ROT_1:
            begin
                top = BANK_2;
                mid = BANK_0;
                btm = BANK_1;
            end
            default:
            begin
                top = BANK_0;
                mid = BANK_1;
                btm = BANK_2;
            end
        endcase

        line_mem[btm][col] = (item.func == FUNC_PIXEL) ? item.pixel_in : 8'd0;
        win[0][2] = line_mem[top][col];
        win[1][2] = line_mem[mid][col];
        win[2][2] = line_mem[btm][col];

        gx = 2 * win[1][2] - 2 * win[1][0] + win[0][2] + win[2][2] - win[0][0] - win[2][0];
        gy = 2 * win[2][1] - 2 * win[0][1] + win[2][0] + win[2][2] - win[0][0] - win[0][2];
        mag = clip255(gx) + clip255(gy);
        if (mag > int'(PIX_MAX)) mag = int'(PIX_MAX);
        res.edge_pixel = 8'(mag);
        res.frame_last = (row_cnt == rows) && (col + 1 >= cols);
        edge_due.push_back(res);

        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end

        if (col + 1 >= cols)
        begin
            col_cnt = 0;
            case (rot)
                ROT_0:   rot = ROT_1;
                ROT_1:   rot = ROT_2;
                default: rot = ROT_0;
            endcase
            row_cnt++;
            clear_old_cols();
            if (row_cnt > rows) restart_frame();
        end
        else
        begin
            col_cnt = col + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg = ROWS_RESET;
            cols_reg = COLS_RESET;
            restart_frame();
            edge_due.delete();
            fails = 0;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (edge_valid && !edge_stall)
            begin
                if (edge_due.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected edge result: pixel %0d last %0d",
                                 $time, edge_item.edge_pixel, edge_item.frame_last);
                end
                else
                begin
                    want_res = edge_due.pop_front();
                    if (edge_item.edge_pixel !== want_res.edge_pixel ||
                        edge_item.frame_last !== want_res.frame_last)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: edge result mismatch: expected pixel %0d ",
                                      "last %0d, got pixel %0d last %0d"},
                                     $time, want_res.edge_pixel, want_res.frame_last,
                                     edge_item.edge_pixel, edge_item.frame_last);
                    end
                end
            end
            // An item taken at this edge still sees the old register values.
            if (pix_valid && !pix_stall) predict_item(pix_item);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_ROWS) rows_reg = cfg_data;
                else if (cfg_index == REG_FRAME_COLS) cols_reg = cfg_data[11:0];
            end
            mismatch_count <= fails;
            outstanding <= edge_due.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// Stimulus and verdict for the Sobel edge filter: frames of pixels, pad ticks and register writes.
`timescale 1ns / 1ps

module tb_top
    import sobel_pkg::*;
;

    localparam int FRAME_ROWS_MAX = 4096;
    localparam int FRAME_COLS_MAX = 2048;

    typedef enum int {STYLE_NOISE, STYLE_BINARY, STYLE_FLAT} pix_style_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    sobel_in_t              pix_item = '0;
    logic                   edge_valid;
    logic                   edge_stall = 1'b0;
    sobel_out_t             edge_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_ROWS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int         mismatch_count;
    int         outstanding;
    int         src_idle = 35;
    int         dst_stall = 82;
    int         noise_pct = 6;
    int         items_sent = 0;
    pix_style_t pix_style = STYLE_NOISE;

    sobel_edge_line_buffer_filter_unit #(
        .MAX_COLS(FRAME_COLS_MAX),
        .MAX_ROWS(FRAME_ROWS_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_item(pix_item),
        .edge_valid(edge_valid),
        .edge_stall(edge_stall),
        .edge_item(edge_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sobel_edge_monitor #(
        .MAX_COLS(FRAME_COLS_MAX),
        .MAX_ROWS(FRAME_ROWS_MAX)
    ) edge_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_item(pix_item),
        .edge_valid(edge_valid),
        .edge_stall(edge_stall),
        .edge_item(edge_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) edge_stall <= ($urandom_range(99) < dst_stall);
    end

    function automatic logic [7:0] pick_pixel();
        case (pix_style)
            STYLE_NOISE:  return 8'($urandom_range(255));
            STYLE_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            default:      return 8'($urandom_range(140, 100));
        endcase
    endfunction

    // Valid is left high after acceptance so that back-to-back items follow without a gap.
    task automatic send_item(input logic kind, input logic [7:0] pix);
        while ($urandom_range(99) < src_idle)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_item <= '{func: kind, pixel_in: pix};
        @(posedge clk);
        while (pix_stall) @(posedge clk);
    endtask

    // Sends count items of the kind that the given row expects, with wrong-kind noise mixed in.
    task automatic send_span(input int rows, input int row, input int count);
        logic kind;
        kind = (row < rows) ? FUNC_PIXEL : FUNC_PAD;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < noise_pct) send_item(~kind, 8'($urandom_range(255)));
            send_item(kind, pick_pixel());
            items_sent++;
        end
    endtask

    task automatic send_rows(input int rows, input int cols, input int first, input int last);
        for (int r = first; r <= last; r++)
        begin
            send_span(rows, r, cols);
        end
    endtask

    // Registers change only once the filter has drained, so no item sees a half-written setting.
    task automatic set_frame(input int rows, input int cols);
        pix_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_ROWS;
        cfg_data <= CFG_DATA_W'(rows);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= REG_FRAME_COLS;
        cfg_data <= CFG_DATA_W'(cols);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(input int rows, input int cols);
        int eff_r;
        int eff_c;
        eff_r = (rows < 1) ? 1 : (rows > FRAME_ROWS_MAX) ? FRAME_ROWS_MAX : rows;
        eff_c = (cols < 1) ? 1 : (cols > FRAME_COLS_MAX) ? FRAME_COLS_MAX : cols;
        set_frame(rows, cols);
        send_rows(eff_r, eff_c, 0, eff_r);
    endtask

    // Every scenario starts and ends on a frame boundary.
    task automatic random_scenario();
        int pick;
        int rows;
        int cols;
        int k;
        int m;
        int r2;
        int c2;

        pick = $urandom_range(99);
        pix_style = pix_style_t'($urandom_range(2));
        rows = $urandom_range(5, 1);
        cols = $urandom_range(12, 1);
        if ($urandom_range(9) == 0) cols = $urandom_range(48, 13);

        if (pick < 70)
        begin
            run_frame(rows, cols);
        end
        else if (pick < 80)
        begin
            // Narrow the row while the column counter is already past the new width.
            cols = $urandom_range(16, 4);
            set_frame(rows, cols);
            k = $urandom_range(rows, 0);
            m = $urandom_range(cols - 1, 2);
            send_rows(rows, cols, 0, k - 1);
            send_span(rows, k, m);
            c2 = $urandom_range(m, 1);
            set_frame(rows, c2);
            send_span(rows, k, 1);
            send_rows(rows, c2, k + 1, rows);
        end
        else if (pick < 90)
        begin
            // Drop the row count below the current row, which restarts the frame.
            rows = $urandom_range(6, 3);
            set_frame(rows, cols);
            k = $urandom_range(rows, 2);
            send_rows(rows, cols, 0, k - 1);
            send_span(rows, k, $urandom_range(cols - 1, 0));
            r2 = $urandom_range(k - 1, 1);
            run_frame(r2, cols);
        end
        else
        begin
            // Raise the row count mid-frame; if the pad row was already begun, it turns back into pixels.
            rows = $urandom_range(4, 1);
            set_frame(rows, cols);
            k = $urandom_range(rows, 0);
            m = $urandom_range(cols - 1, 0);
            send_rows(rows, cols, 0, k - 1);
            send_span(rows, k, m);
            r2 = rows + $urandom_range(3, 1);
            set_frame(r2, cols);
            send_span(r2, k, cols - m);
            send_rows(r2, cols, k + 1, r2);
        end
    endtask

    initial
    begin
        int target;
        int wait_cnt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two image rows of hard edges, wrong-kind items in every row, then the pad row.
        set_frame(2, 3);
        send_item(FUNC_PAD, 8'hFF);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h00);
        send_item(FUNC_PAD, 8'h00);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h4D);
        send_item(FUNC_PAD, 8'hFF);
        send_item(FUNC_PAD, 8'h00);
        send_item(FUNC_PAD, 8'hAA);

        // Zero in both registers clamps to a one-pixel frame.
        set_frame(0, 0);
        send_item(FUNC_PIXEL, 8'hFF);
        send_item(FUNC_PIXEL, 8'h55);
        send_item(FUNC_PAD, 8'h00);

        // Two rows in, the row count drops to one and the frame starts over.
        set_frame(3, 2);
        send_item(FUNC_PIXEL, 8'h01);
        send_item(FUNC_PIXEL, 8'h80);
        send_item(FUNC_PIXEL, 8'hFE);
        send_item(FUNC_PIXEL, 8'h7F);
        set_frame(1, 2);
        send_item(FUNC_PIXEL, 8'hF0);
        send_item(FUNC_PIXEL, 8'h0F);
        send_item(FUNC_PAD, 8'h00);
        send_item(FUNC_PAD, 8'h00);

        target = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle = (phase == 0) ? 35 : (phase == 1) ? 82 : 0;
            dst_stall = (phase == 0) ? 82 : (phase == 1) ? 35 : 0;
            target += 250;
            while (items_sent < target) random_scenario();
        end

        pix_valid <= 1'b0;
        @(posedge clk);
        wait_cnt = 0;
        while (outstanding != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
